FILE: rtl/bdiou_pkg.sv
`timescale 1ns / 1ps

package bdiou_pkg;

    localparam int unsigned CoordW  = 16;
    localparam int unsigned EdgeW   = 18;
    localparam int unsigned SpanW   = 17;
    localparam int unsigned EncW    = 18;
    localparam int unsigned InterW  = 34;
    localparam int unsigned UniW    = 35;
    localparam int unsigned DistW   = 35;
    localparam int unsigned DiagW   = 37;
    localparam int unsigned RemW    = 52;
    localparam int unsigned QuoW    = 15;
    localparam int unsigned FracW   = 14;
    localparam int unsigned ProdW   = UniW + DiagW;
    localparam int unsigned SplitW  = 18;
    localparam int unsigned InTdataW  = 128;
    localparam int unsigned OutTdataW = 24;
    localparam int unsigned ScoreW  = 16;
    localparam int unsigned StatusW = 2;

    localparam logic [StatusW-1:0] StatusOk       = 2'd0;
    localparam logic [StatusW-1:0] StatusDisjoint = 2'd1;
    localparam logic [StatusW-1:0] StatusNoUnion  = 2'd2;

    localparam logic signed [16:0] ScoreOne    = 17'sd16384;
    localparam logic signed [16:0] ScoreNegOne = -17'sd16384;

    typedef struct packed {
        logic              vld;
        logic              disj;
        logic              uzero;
        logic              dzero;
        logic [RemW-1:0]   rem1;
        logic [RemW-1:0]   rem2;
        logic [UniW-1:0]   uni;
        logic [DiagW-1:0]  diag;
        logic [QuoW-1:0]   q1;
        logic [QuoW-1:0]   q2;
    } t_div;

endpackage

FILE: rtl/box_diou_score_core.sv
`timescale 1ns / 1ps
// box_diou_score_core: Distance-IoU score of two center-format boxes.
// Input channel (i_s_*): one word per box pair, eight 16-bit fields in tdata.
// Output channel (o_m_*): one word per pair, score (Q2.14) and status code.
// Status 0 = computed, 1 = disjoint boxes (score 0), 2 = zero union (score 0).
// Throughput: one pair per cycle while no output stall holds the pipeline;
// the pipeline is 21 register stages deep: edge/overlap stage, multiply
// stage, setup stage, fifteen restoring divider stages (one quotient bit
// each for both quotients), a split-multiply stage, a product sum stage
// and the final compare/round/output stage.
// Reset (synchronous, active low) clears all valid bits; data in flight is
// dropped. When the receiver deasserts i_m_tready while a result waits, the
// whole pipeline holds and o_s_tready falls; nothing is lost or repeated.
module box_diou_score_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // a_center_x, a_center_y, a_width, a_height,
    // b_center_x, b_center_y, b_width, b_height (16 bits each)
    input  logic [bdiou_pkg::InTdataW-1:0]     i_s_tdata,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // score [15:0], status [17:16], zero [23:18]
    output logic [bdiou_pkg::OutTdataW-1:0]    o_m_tdata
);

    localparam int unsigned NDiv = bdiou_pkg::QuoW + 1;

    logic w_en;

    logic signed [15:0] w_acx, w_acy, w_bcx, w_bcy;
    logic [15:0]        w_aw, w_ah, w_bw, w_bh;
    logic signed [bdiou_pkg::EdgeW-1:0] w_al, w_ar, w_at, w_ab, w_bl, w_br, w_bt, w_bb;
    logic signed [bdiou_pkg::EdgeW-1:0] w_il, w_ir, w_it, w_ib;
    logic signed [bdiou_pkg::EdgeW:0]   w_iw, w_ih, w_ex, w_ey;
    logic signed [16:0]                 w_dxh, w_dyh;

    logic                                r_s1_vld, r_s1_disj;
    logic [bdiou_pkg::SpanW-1:0]         r_s1_iw, r_s1_ih;
    logic [bdiou_pkg::EncW-1:0]          r_s1_ex, r_s1_ey;
    logic signed [17:0]                  r_s1_dx, r_s1_dy;
    logic [15:0]                         r_s1_aw, r_s1_ah, r_s1_bw, r_s1_bh;

    logic                                r_s2_vld, r_s2_disj;
    logic [bdiou_pkg::InterW-1:0]        r_s2_inter;
    logic [31:0]                         r_s2_aa, r_s2_ba;
    logic [33:0]                         r_s2_dx2, r_s2_dy2;
    logic [35:0]                         r_s2_ex2, r_s2_ey2;
    logic signed [35:0]                  w_dx2, w_dy2;

    logic [bdiou_pkg::UniW-1:0]          w_uni;
    logic [bdiou_pkg::DistW-1:0]         w_dist;
    logic [bdiou_pkg::DiagW-1:0]         w_diag;

    bdiou_pkg::t_div r_div [0:NDiv-1];
    bdiou_pkg::t_div n_div [0:NDiv-1];

    logic                                r_sm_vld, r_sm_disj, r_sm_uzero, r_sm_dzero, r_sm_r1nz;
    logic [bdiou_pkg::QuoW-1:0]          r_sm_q1, r_sm_q2;
    logic [35:0]                         r_sm_p1hh, r_sm_p1hl, r_sm_p1lh, r_sm_p1ll;
    logic [35:0]                         r_sm_p2hh, r_sm_p2hl, r_sm_p2lh, r_sm_p2ll;
    logic [bdiou_pkg::UniW-1:0]          w_r1;
    logic [bdiou_pkg::DiagW-1:0]         w_r2;

    logic                                r_ss_vld, r_ss_disj, r_ss_uzero, r_ss_dzero, r_ss_r1nz;
    logic [bdiou_pkg::QuoW-1:0]          r_ss_q1, r_ss_q2;
    logic [bdiou_pkg::ProdW-1:0]         r_ss_p1, r_ss_p2;

    logic                                r_out_vld;
    logic [bdiou_pkg::ScoreW-1:0]        r_score;
    logic [bdiou_pkg::StatusW-1:0]       r_status;
    logic [bdiou_pkg::ScoreW-1:0]        n_score;
    logic [bdiou_pkg::StatusW-1:0]       n_status;
    logic signed [16:0]                  w_d;
    logic                                w_epos, w_eneg;
    logic [bdiou_pkg::QuoW-1:0]          w_q2e;

    assign w_en       = !r_out_vld || i_m_tready;
    assign o_s_tready = w_en;
    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {6'd0, r_status, r_score};

    // edges and overlap
    always_comb begin
        w_acx = $signed(i_s_tdata[15:0]);
        w_acy = $signed(i_s_tdata[31:16]);
        w_aw  = i_s_tdata[47:32];
        w_ah  = i_s_tdata[63:48];
        w_bcx = $signed(i_s_tdata[79:64]);
        w_bcy = $signed(i_s_tdata[95:80]);
        w_bw  = i_s_tdata[111:96];
        w_bh  = i_s_tdata[127:112];
        w_al = $signed({w_acx[15], w_acx, 1'b0}) - $signed({2'b00, w_aw});
        w_ar = $signed({w_acx[15], w_acx, 1'b0}) + $signed({2'b00, w_aw});
        w_at = $signed({w_acy[15], w_acy, 1'b0}) - $signed({2'b00, w_ah});
        w_ab = $signed({w_acy[15], w_acy, 1'b0}) + $signed({2'b00, w_ah});
        w_bl = $signed({w_bcx[15], w_bcx, 1'b0}) - $signed({2'b00, w_bw});
        w_br = $signed({w_bcx[15], w_bcx, 1'b0}) + $signed({2'b00, w_bw});
        w_bt = $signed({w_bcy[15], w_bcy, 1'b0}) - $signed({2'b00, w_bh});
        w_bb = $signed({w_bcy[15], w_bcy, 1'b0}) + $signed({2'b00, w_bh});
        w_il = (w_al > w_bl) ? w_al : w_bl;
        w_ir = (w_ar < w_br) ? w_ar : w_br;
        w_it = (w_at > w_bt) ? w_at : w_bt;
        w_ib = (w_ab < w_bb) ? w_ab : w_bb;
        w_iw = $signed({w_ir[17], w_ir}) - $signed({w_il[17], w_il});
        w_ih = $signed({w_ib[17], w_ib}) - $signed({w_it[17], w_it});
        w_ex = $signed({((w_ar > w_br) ? w_ar[17] : w_br[17]), ((w_ar > w_br) ? w_ar : w_br)})
             - $signed({((w_al < w_bl) ? w_al[17] : w_bl[17]), ((w_al < w_bl) ? w_al : w_bl)});
        w_ey = $signed({((w_ab > w_bb) ? w_ab[17] : w_bb[17]), ((w_ab > w_bb) ? w_ab : w_bb)})
             - $signed({((w_at < w_bt) ? w_at[17] : w_bt[17]), ((w_at < w_bt) ? w_at : w_bt)});
        w_dxh = $signed({w_acx[15], w_acx}) - $signed({w_bcx[15], w_bcx});
        w_dyh = $signed({w_acy[15], w_acy}) - $signed({w_bcy[15], w_bcy});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_en) begin
            r_s1_vld <= i_s_tvalid;
        end
        if (w_en) begin
            r_s1_disj <= (w_ib < w_it) || (w_ir < w_il);
            r_s1_iw   <= w_iw[16:0];
            r_s1_ih   <= w_ih[16:0];
            r_s1_ex   <= w_ex[17:0];
            r_s1_ey   <= w_ey[17:0];
            r_s1_dx   <= {w_dxh, 1'b0};
            r_s1_dy   <= {w_dyh, 1'b0};
            r_s1_aw   <= w_aw;
            r_s1_ah   <= w_ah;
            r_s1_bw   <= w_bw;
            r_s1_bh   <= w_bh;
        end
    end

    // products
    assign w_dx2 = r_s1_dx * r_s1_dx;
    assign w_dy2 = r_s1_dy * r_s1_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (w_en) begin
            r_s2_vld <= r_s1_vld;
        end
        if (w_en) begin
            r_s2_disj  <= r_s1_disj;
            r_s2_inter <= 34'(r_s1_iw) * 34'(r_s1_ih);
            r_s2_aa    <= 32'(r_s1_aw) * 32'(r_s1_ah);
            r_s2_ba    <= 32'(r_s1_bw) * 32'(r_s1_bh);
            r_s2_dx2   <= w_dx2[33:0];
            r_s2_dy2   <= w_dy2[33:0];
            r_s2_ex2   <= 36'(r_s1_ex) * 36'(r_s1_ex);
            r_s2_ey2   <= 36'(r_s1_ey) * 36'(r_s1_ey);
        end
    end

    // union, distance, diagonal; divider setup
    always_comb begin
        w_uni  = (35'({1'b0, r_s2_aa} + {1'b0, r_s2_ba}) << 2) - 35'(r_s2_inter);
        w_dist = 35'(r_s2_dx2) + 35'(r_s2_dy2);
        w_diag = 37'(r_s2_ex2) + 37'(r_s2_ey2);
        n_div[0].vld   = r_s2_vld;
        n_div[0].disj  = r_s2_disj;
        n_div[0].uzero = (w_uni == '0);
        n_div[0].dzero = (w_diag == '0);
        n_div[0].rem1  = 52'(r_s2_inter) << bdiou_pkg::FracW;
        n_div[0].rem2  = 52'(w_dist) << bdiou_pkg::FracW;
        n_div[0].uni   = w_uni;
        n_div[0].diag  = w_diag;
        n_div[0].q1    = '0;
        n_div[0].q2    = '0;
    end

    // restoring dividers, one quotient bit per stage
    for (genvar k = 1; k < NDiv; k++) begin : g_div
        localparam int unsigned Bit = NDiv - 1 - k;
        logic [bdiou_pkg::RemW-1:0] w_t1, w_t2;
        always_comb begin
            w_t1 = 52'(r_div[k-1].uni) << Bit;
            w_t2 = 52'(r_div[k-1].diag) << Bit;
            n_div[k] = r_div[k-1];
            if (r_div[k-1].rem1 >= w_t1) begin
                n_div[k].rem1    = r_div[k-1].rem1 - w_t1;
                n_div[k].q1[Bit] = 1'b1;
            end
            if (r_div[k-1].rem2 >= w_t2) begin
                n_div[k].rem2    = r_div[k-1].rem2 - w_t2;
                n_div[k].q2[Bit] = 1'b1;
            end
        end
    end

    for (genvar k = 0; k < NDiv; k++) begin : g_div_reg
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_div[k] <= '0;
            end else if (w_en) begin
                r_div[k] <= n_div[k];
            end
        end
    end

    // split products of the remainders for the exact fraction compare
    assign w_r1 = r_div[NDiv-1].rem1[bdiou_pkg::UniW-1:0];
    assign w_r2 = r_div[NDiv-1].rem2[bdiou_pkg::DiagW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sm_vld <= 1'b0;
        end else if (w_en) begin
            r_sm_vld <= r_div[NDiv-1].vld;
        end
        if (w_en) begin
            r_sm_disj  <= r_div[NDiv-1].disj;
            r_sm_uzero <= r_div[NDiv-1].uzero;
            r_sm_dzero <= r_div[NDiv-1].dzero;
            r_sm_r1nz  <= (w_r1 != '0);
            r_sm_q1    <= r_div[NDiv-1].q1;
            r_sm_q2    <= r_div[NDiv-1].q2;
            r_sm_p1hh  <= 36'(w_r1[34:18]) * 36'(r_div[NDiv-1].diag[36:18]);
            r_sm_p1hl  <= 36'(w_r1[34:18]) * 36'(r_div[NDiv-1].diag[17:0]);
            r_sm_p1lh  <= 36'(w_r1[17:0]) * 36'(r_div[NDiv-1].diag[36:18]);
            r_sm_p1ll  <= 36'(w_r1[17:0]) * 36'(r_div[NDiv-1].diag[17:0]);
            r_sm_p2hh  <= 36'(w_r2[36:18]) * 36'(r_div[NDiv-1].uni[34:18]);
            r_sm_p2hl  <= 36'(w_r2[36:18]) * 36'(r_div[NDiv-1].uni[17:0]);
            r_sm_p2lh  <= 36'(w_r2[17:0]) * 36'(r_div[NDiv-1].uni[34:18]);
            r_sm_p2ll  <= 36'(w_r2[17:0]) * 36'(r_div[NDiv-1].uni[17:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ss_vld <= 1'b0;
        end else if (w_en) begin
            r_ss_vld <= r_sm_vld;
        end
        if (w_en) begin
            r_ss_disj  <= r_sm_disj;
            r_ss_uzero <= r_sm_uzero;
            r_ss_dzero <= r_sm_dzero;
            r_ss_r1nz  <= r_sm_r1nz;
            r_ss_q1    <= r_sm_q1;
            r_ss_q2    <= r_sm_q2;
            r_ss_p1 <= (72'(r_sm_p1hh) << (2 * bdiou_pkg::SplitW))
                     + (72'(r_sm_p1hl) << bdiou_pkg::SplitW)
                     + (72'(r_sm_p1lh) << bdiou_pkg::SplitW) + 72'(r_sm_p1ll);
            r_ss_p2 <= (72'(r_sm_p2hh) << (2 * bdiou_pkg::SplitW))
                     + (72'(r_sm_p2hl) << bdiou_pkg::SplitW)
                     + (72'(r_sm_p2lh) << bdiou_pkg::SplitW) + 72'(r_sm_p2ll);
        end
    end

    // round toward zero, clamp, pick status
    always_comb begin
        w_q2e  = r_ss_dzero ? '0 : r_ss_q2;
        w_epos = r_ss_dzero ? r_ss_r1nz : (r_ss_p1 > r_ss_p2);
        w_eneg = r_ss_dzero ? 1'b0 : (r_ss_p1 < r_ss_p2);
        w_d    = $signed({2'b00, r_ss_q1}) - $signed({2'b00, w_q2e});
        if (w_d > 17'sd0 && w_eneg) begin
            w_d = w_d - 17'sd1;
        end else if (w_d < 17'sd0 && w_epos) begin
            w_d = w_d + 17'sd1;
        end
        if (w_d > bdiou_pkg::ScoreOne) begin
            w_d = bdiou_pkg::ScoreOne;
        end
        if (w_d < bdiou_pkg::ScoreNegOne) begin
            w_d = bdiou_pkg::ScoreNegOne;
        end
        if (r_ss_disj) begin
            n_status = bdiou_pkg::StatusDisjoint;
            n_score  = '0;
        end else if (r_ss_uzero) begin
            n_status = bdiou_pkg::StatusNoUnion;
            n_score  = '0;
        end else begin
            n_status = bdiou_pkg::StatusOk;
            n_score  = w_d[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= r_ss_vld;
        end
        if (w_en) begin
            r_score  <= n_score;
            r_status <= n_status;
        end
    end

endmodule

FILE: rtl/bdiou_checker.sv
`timescale 1ns / 1ps

module bdiou_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_s_tvalid,
    input logic                               o_s_tready,
    input logic [bdiou_pkg::InTdataW-1:0]     i_s_tdata,
    input logic                               o_m_tvalid,
    input logic                               i_m_tready,
    input logic [bdiou_pkg::OutTdataW-1:0]    o_m_tdata
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result dropped or changed under stall");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready == (!o_m_tvalid || i_m_tready))
        else $error("input ready does not follow output stage");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[17:16] != 2'd3)
        else $error("invalid status code");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[17:16] != bdiou_pkg::StatusOk |-> o_m_tdata[15:0] == 16'd0)
        else $error("nonzero score with nonzero status");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ($signed(o_m_tdata[15:0]) <= 16'sd16384
                     && $signed(o_m_tdata[15:0]) >= -16'sd16384))
        else $error("score out of range");

endmodule

bind box_diou_score_core bdiou_checker u_bdiou_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
